@@ hdl/ltlb_pkg.sv @@
// Shared types and constants for the LRU translation lookaside buffer.
package ltlb_pkg;

  localparam int ENTRIES = 16;
  localparam int AGE_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 32;
  localparam int ADDR_W  = 32;
  localparam int CMD_W   = 2;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(ENTRIES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef logic [AGE_W-1:0] age_t;

endpackage

@@ hdl/ltlb_ifs.sv @@
// Valid/ready channel interfaces for the LRU translation lookaside buffer.
interface ltlb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ltlb_pkg::CMD_W-1:0]    cmd;
  logic [ltlb_pkg::KEY_W-1:0]    vkey;
  logic [ltlb_pkg::ADDR_W-1:0]   paddr;

  modport source (output valid, output cmd, output vkey, output paddr, input ready);
  modport sink   (input valid, input cmd, input vkey, input paddr, output ready);
endinterface

interface ltlb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [ltlb_pkg::ADDR_W-1:0]   found_addr;

  modport source (output valid, output hit, output found_addr, input ready);
  modport sink   (input valid, input hit, input found_addr, output ready);
endinterface

@@ hdl/lru_translation_lookaside_buffer.sv @@
// Fully associative LRU translation lookaside buffer, top level.
// A word is taken into an input register, then its key is compared against
// every valid entry in parallel, the recency ranks and entries are updated and
// the result lands in an output register. The block takes one word per cycle;
// the parallel key compare and the most-recent-match select across all ENTRIES
// entries set the clock period. It stalls only when the output register is
// full and not being taken. A lookup returns hit and the stored address (zero
// on a miss); add, flush and the unused command return hit 0 and address 0.
// Add writes a new most-recent entry into the lowest free slot or over the
// least recent entry when full; flush clears every entry at once.
module lru_translation_lookaside_buffer (
  input  logic        clk,
  input  logic        rst_n,
  ltlb_in_if.sink     in_chan,
  ltlb_out_if.source  out_chan
);
  import ltlb_pkg::*;

  logic              s1_v_r;
  cmd_t              s1_cmd_r;
  logic [KEY_W-1:0]  s1_vkey_r;
  logic [ADDR_W-1:0] s1_paddr_r;

  logic [KEY_W-1:0]  entry_key_r  [ENTRIES];
  logic [ADDR_W-1:0] entry_addr_r [ENTRIES];
  logic [ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  age_t              entry_age_r  [ENTRIES];
  age_t              entry_age_nxt[ENTRIES];

  logic              out_v_r;
  logic              out_hit_r, out_hit_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic               advance;
  logic [ENTRIES-1:0] match, best, free_slot, victim, wr_sel;
  logic               hit_any, full;
  age_t               best_age;
  logic [ADDR_W-1:0]  hit_addr;

  assign advance       = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || advance;

  // Hold the accepted word until it moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_v_r <= 1'b1;
    end else if (advance) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_cmd_r   <= cmd_t'(in_chan.cmd);
      s1_vkey_r  <= in_chan.vkey;
      s1_paddr_r <= in_chan.paddr;
    end
  end

  // Compare, pick the most recent match, and locate free and victim slots.
  always_comb begin
    match     = '0;
    best      = '0;
    free_slot = '0;
    victim    = '0;
    best_age  = '0;
    hit_addr  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid_r[i] && (entry_key_r[i] == s1_vkey_r);
      victim[i] = (entry_age_r[i] == AGE_MAX);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      best[i]      = match[i];
      free_slot[i] = !entry_valid_r[i];
      for (int j = 0; j < ENTRIES; j++) begin
        if (j != i && match[j] && ((entry_age_r[j] < entry_age_r[i]) ||
            ((entry_age_r[j] == entry_age_r[i]) && (j < i)))) begin
          best[i] = 1'b0;
        end
        if (j < i && !entry_valid_r[j]) begin
          free_slot[i] = 1'b0;
        end
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (best[i]) begin
        best_age = best_age | entry_age_r[i];
        hit_addr = hit_addr | entry_addr_r[i];
      end
    end
  end

  assign hit_any = |match;
  assign full    = &entry_valid_r;

  always_comb begin
    entry_valid_nxt = entry_valid_r;
    entry_age_nxt   = entry_age_r;
    wr_sel          = '0;
    out_hit_nxt     = 1'b0;
    out_addr_nxt    = '0;
    case (s1_cmd_r)
      CMD_LOOKUP: begin
        if (hit_any) begin
          out_hit_nxt  = 1'b1;
          out_addr_nxt = hit_addr;
          for (int i = 0; i < ENTRIES; i++) begin
            if (best[i]) begin
              entry_age_nxt[i] = '0;
            end else if (entry_valid_r[i] && (entry_age_r[i] < best_age)) begin
              entry_age_nxt[i] = entry_age_r[i] + age_t'(1);
            end
          end
        end
      end
      CMD_ADD: begin
        wr_sel = full ? victim : free_slot;
        for (int i = 0; i < ENTRIES; i++) begin
          if (wr_sel[i]) begin
            entry_valid_nxt[i] = 1'b1;
            entry_age_nxt[i]   = '0;
          end else if (entry_valid_r[i]) begin
            entry_age_nxt[i] = entry_age_r[i] + age_t'(1);
          end
        end
      end
      CMD_FLUSH: begin
        entry_valid_nxt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          entry_age_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age_r[i] <= '0;
      end
    end else if (advance) begin
      entry_valid_r <= entry_valid_nxt;
      entry_age_r   <= entry_age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (advance && wr_sel[i]) begin
        entry_key_r[i]  <= s1_vkey_r;
        entry_addr_r[i] <= s1_paddr_r;
      end
    end
  end

  // Present the result; drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r  <= out_hit_nxt;
      out_addr_r <= out_addr_nxt;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.found_addr = out_addr_r;

endmodule

@@ hdl/ltlb_chk.sv @@
// Port-level assertion checker for the LRU translation lookaside buffer.
module ltlb_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [ltlb_pkg::ADDR_W-1:0] out_found_addr
);
  import ltlb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_found_addr))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_addr == '0)
    else $error("nonzero address without a hit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

endmodule

bind lru_translation_lookaside_buffer ltlb_chk u_ltlb_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_hit        (out_chan.hit),
  .out_found_addr (out_chan.found_addr)
);

@@ tb/sv/tb_top.sv @@
// Testbench for the LRU translation lookaside buffer: predicts every result and checks it.
`timescale 1ns / 100ps

module tb_top;
  import ltlb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int KEY_POOL  = 24;
  localparam int N_RANDOM  = 600;
  localparam int HOLD_AT   = 180;
  localparam int HOLD_LEN  = 60;
  localparam int QUIET_LO  = 320;
  localparam int QUIET_HI  = 440;
  localparam int SYNC_AT   = 500;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  vkey;
    logic [ADDR_W-1:0] paddr;
    bit                sync;
  } xlat_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } xlat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ltlb_in_if  in_if ();
  ltlb_out_if out_if ();

  lru_translation_lookaside_buffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the buffer contents
  logic [KEY_W-1:0]  tlb_key  [ENTRIES];
  logic [ADDR_W-1:0] tlb_addr [ENTRIES];
  bit                tlb_valid[ENTRIES];
  age_t              tlb_age  [ENTRIES];

  xlat_req_t  req_q[$];
  xlat_t      xlat_q[$];
  logic [KEY_W-1:0] key_pool[KEY_POOL];

  int  errors = 0;
  int  n_taken = 0;
  int  n_results = 0;
  int  n_lookups = 0;
  int  n_hits = 0;
  int  n_adds = 0;
  int  n_evicts = 0;
  int  n_flushes = 0;
  int  n_unused = 0;
  bit  in_took = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  wire quiet = (n_taken >= QUIET_LO) && (n_taken < QUIET_HI);

  function automatic void tlb_promote(int slot, age_t old_rank);
    for (int i = 0; i < ENTRIES; i++)
      if (tlb_valid[i] && tlb_age[i] < old_rank) tlb_age[i]++;
    tlb_age[slot] = '0;
  endfunction

  function automatic xlat_t tlb_translate(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [ADDR_W-1:0] pa);
    xlat_t res;
    int    best;
    int    slot;
    int    count;
    res = '0;
    case (cmd)
      CMD_LOOKUP: begin
        n_lookups++;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (tlb_valid[i] && tlb_key[i] == key && (best < 0 || tlb_age[i] < tlb_age[best]))
            best = i;
        if (best >= 0) begin
          n_hits++;
          res.hit  = 1'b1;
          res.addr = tlb_addr[best];
          tlb_promote(best, tlb_age[best]);
        end
      end
      CMD_ADD: begin
        n_adds++;
        slot  = -1;
        count = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (tlb_valid[i]) count++;
          else if (slot < 0) slot = i;
        if (slot < 0) begin
          n_evicts++;
          for (int i = 0; i < ENTRIES; i++)
            if (tlb_age[i] == AGE_MAX) slot = i;
          tlb_promote(slot, AGE_MAX);
        end else begin
          tlb_valid[slot] = 1'b1;
          tlb_promote(slot, age_t'(count));
        end
        tlb_key[slot]  = key;
        tlb_addr[slot] = pa;
      end
      CMD_FLUSH: begin
        n_flushes++;
        for (int i = 0; i < ENTRIES; i++) begin
          tlb_valid[i] = 1'b0;
          tlb_age[i]   = '0;
        end
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at word %0d: %s got %h expected %h", n_results, what, got, want);
    errors++;
  endtask

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                          logic [ADDR_W-1:0] pa, bit sync = 1'b0);
    xlat_req_t r;
    r.cmd   = cmd;
    r.vkey  = key;
    r.paddr = pa;
    r.sync  = sync;
    req_q.push_back(r);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    return ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  // monitor: check results, then predict accepted words
  always @(posedge clk) begin
    xlat_t want;
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (xlat_q.size() == 0) begin
          report_mismatch("unexpected result, hit/addr", {31'b0, out_if.hit}, 32'b0);
        end else begin
          want = xlat_q.pop_front();
          if (out_if.hit !== want.hit)
            report_mismatch("hit", {31'b0, out_if.hit}, {31'b0, want.hit});
          if (out_if.found_addr !== want.addr)
            report_mismatch("found_addr", out_if.found_addr, want.addr);
        end
        n_results++;
      end
      if (in_if.valid && in_if.ready) begin
        xlat_q.push_back(tlb_translate(in_if.cmd, in_if.vkey, in_if.paddr));
        void'(req_q.pop_front());
        n_taken++;
      end
    end
  end

  // driver: hold a word until taken, then offer the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (req_q.size() > 0 && (quiet || $urandom_range(99) >= 6) &&
          !(req_q[0].sync && xlat_q.size() != 0)) begin
        in_if.valid <= 1'b1;
        in_if.cmd   <= req_q[0].cmd;
        in_if.vkey  <= req_q[0].vkey;
        in_if.paddr <= req_q[0].paddr;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= quiet || $urandom_range(99) >= 6;
    end
  end

  initial begin
    int r;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_LOOKUP;
    in_if.vkey   = '0;
    in_if.paddr  = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_age[i]   = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    push_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF);
    push_req(CMD_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
    push_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(CMD_ADD,    32'h0000_0000, 32'h5A5A_A5A5);
    push_req(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    push_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(CMD_FLUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);

    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(99);
      if (r < 50)      push_req(CMD_LOOKUP, pick_key(), $urandom, n == SYNC_AT);
      else if (r < 88) push_req(CMD_ADD,    pick_key(), $urandom, n == SYNC_AT);
      else if (r < 91) push_req(CMD_FLUSH,  $urandom,   $urandom, n == SYNC_AT);
      else if (r < 95) push_req(CMD_UNUSED, $urandom,   $urandom, n == SYNC_AT);
      else             push_req(CMD_LOOKUP, $urandom,   $urandom, n == SYNC_AT);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_q.size() != 0 || in_if.valid) @(posedge clk);
    while (xlat_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Checked %0d results from %0d words: %0d lookups (%0d hits), %0d adds",
             n_results, n_taken, n_lookups, n_hits, n_adds);
    $display("  with %0d evictions, %0d flushes and %0d unused commands, %0d mismatches",
             n_evicts, n_flushes, n_unused, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results still expected", xlat_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
